FILE: hdl/mbrx_pkg.sv
// ============================================================================
// mbrx_pkg
// Shared types, constants and the CRC-16 step for the request receiver.
// ============================================================================
package mbrx_pkg;

  // Write-many word limit and word store geometry
  localparam int MAX_WRITE_WORDS = 32;
  localparam int WORD_SLOTS      = 32;
  localparam int WORD_LIMIT      = (MAX_WRITE_WORDS < WORD_SLOTS) ? MAX_WRITE_WORDS
                                                                  : WORD_SLOTS;
  localparam int WADDR_W         = $clog2(WORD_SLOTS);
  localparam int CNT_W           = $clog2(WORD_LIMIT + 1);
  localparam int BPOS_W          = $clog2(2 * WORD_LIMIT) + 1;
  localparam int QUEUE_DEPTH     = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_READ_CODE  = 2'd1;
  localparam logic [1:0] REG_ONE_CODE   = 2'd2;
  localparam logic [1:0] REG_MANY_CODE  = 2'd3;

  // CRC-16, reflected
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Input selector
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_IDLE = 1'b1;

  typedef enum logic [2:0] {
    OUT_READ      = 3'd0,
    OUT_WRITE_ONE = 3'd1,
    OUT_WORD      = 3'd2,
    OUT_CRC_ERR   = 3'd3,
    OUT_ILLEGAL   = 3'd4,
    OUT_TOO_MANY  = 3'd5
  } outcome_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_FUNC = 4'd1,
    PH_HDR  = 4'd2,
    PH_DATA = 4'd3,
    PH_CRCL = 4'd4,
    PH_CRCH = 4'd5,
    PH_SKIP = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_MANY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_OUT  = 2'd2
  } bstate_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] read_code;
    logic [7:0] write_one_code;
    logic [7:0] write_many_code;
  } cfg_t;

  // One decoded request handed from front to back
  typedef struct packed {
    outcome_t         outcome;
    logic [7:0]       function_code;
    logic [15:0]      reg_address;
    logic [15:0]      count_or_value;
    logic             run;
    logic [CNT_W-1:0] n_words;
  } cmd_t;

  // One byte through the CRC-16 shift register
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

endpackage

FILE: hdl/modbus_rtu_request_receiver.sv
// ============================================================================
// modbus_rtu_request_receiver
// Modbus RTU style request parser with CRC-16 check and write-many word run.
// ============================================================================
// The block takes one received byte (or one line-idle mark) per cycle on the
// in_ stream and reports decoded requests, CRC errors, illegal functions and
// over-long write-many counts on the out_ stream. Bytes are accepted at one
// per cycle; in_tready drops only while the two-entry command queue is full
// or while a write-many run is being drained from the 32-word payload
// memory. A single-result command goes from the command fetch straight to
// the output state of the result sequencer. For a write-many run of n words
// the command fetch issues the first memory read, and each word then takes
// one memory read state and one output state, held by any out_tready stall.
// Registers sit at byte addresses 0 (slave address), 4 (read code),
// 8 (write-one code) and 12 (write-many code) of the cfg_ APB port.
// ============================================================================
module modbus_rtu_request_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] rx_byte
  input  logic                               in_tuser,   // [0] func (1 = idle gap)
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] function_code, [23:8] reg_address, [39:24] count_or_value,
  // [44:40] word_index, [60:45] word_value, [63:61] zero
  output logic [63:0]                        out_tdata,
  output logic [2:0]                         out_tuser,  // [2:0] outcome
  output logic                               out_tlast,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mbrx_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mbrx_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mbrx_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import mbrx_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  logic                cfg_wr;
  logic [1:0]          reg_sel;
  logic [7:0]          rd_byte;

  logic                q_push, q_full, q_pop, q_valid, run_done;
  cmd_t                q_in_cmd, q_head_cmd;
  logic                ram_we, ram_re;
  logic [WADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_SLAVE_ADDR: cfg_nxt.slave_address   = cfg_pwdata[7:0];
        REG_READ_CODE:  cfg_nxt.read_code       = cfg_pwdata[7:0];
        REG_ONE_CODE:   cfg_nxt.write_one_code  = cfg_pwdata[7:0];
        REG_MANY_CODE:  cfg_nxt.write_many_code = cfg_pwdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SLAVE_ADDR: rd_byte = cfg_r.slave_address;
      REG_READ_CODE:  rd_byte = cfg_r.read_code;
      REG_ONE_CODE:   rd_byte = cfg_r.write_one_code;
      REG_MANY_CODE:  rd_byte = cfg_r.write_many_code;
      default:        rd_byte = '0;
    endcase
  end

  assign cfg_prdata = {(CFG_DATA_W - 8)'(0), rd_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{slave_address: 8'd1, read_code: 8'd4,
                 write_one_code: 8'd6, write_many_code: 8'd16};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // frame parser
  mbrx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd),
    .q_full    (q_full),
    .run_done  (run_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // command queue
  mbrx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd)
  );

  // payload word store
  mbrx_ram #(
    .WIDTH (16),
    .DEPTH (WORD_SLOTS)
  ) u_words (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // result sequencer
  mbrx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head_cmd),
    .q_pop      (q_pop),
    .run_done   (run_done),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/mbrx_ram.sv
// ============================================================================
// mbrx_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mbrx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: hdl/mbrx_queue.sv
// ============================================================================
// mbrx_queue
// Short command FIFO between the frame parser and the result sequencer.
// ============================================================================
module mbrx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbrx_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mbrx_pkg::cmd_t head_cmd
);

  import mbrx_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTQ_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNTQ_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full       = (count_r == CNTQ_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slots_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push && !full) begin
      wptr_nxt = ptr_inc(wptr_r);
    end
    if (pop && head_valid) begin
      rptr_nxt = ptr_inc(rptr_r);
    end
    if ((push && !full) && !(pop && head_valid)) begin
      count_nxt = count_r + CNTQ_W'(1);
    end else if (!(push && !full) && (pop && head_valid)) begin
      count_nxt = count_r - CNTQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/mbrx_front.sv
// ============================================================================
// mbrx_front
// Frame parser: address match, function decode, header gather, payload
// store, CRC check; pushes one command per completed frame or illegal function code.
// ============================================================================
module mbrx_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbrx_pkg::cfg_t                cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tuser,
  output logic                          q_push,
  output mbrx_pkg::cmd_t                q_cmd,
  input  logic                          q_full,
  input  logic                          run_done,
  output logic                          ram_we,
  output logic [mbrx_pkg::WADDR_W-1:0]  ram_waddr,
  output logic [15:0]                   ram_wdata
);

  import mbrx_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         field_cnt_r, field_cnt_nxt;
  logic [16:0]        bytes_left_r, bytes_left_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [7:0]         crc_low_r, crc_low_nxt;
  logic [7:0]         held_func_r, held_func_nxt;
  logic [15:0]        held_addr_r, held_addr_nxt;
  logic [15:0]        held_count_r, held_count_nxt;
  kind_t              kind_r, kind_nxt;
  logic [BPOS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]         hi_byte_r, hi_byte_nxt;
  logic               run_pending_r, run_pending_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_b;
  logic [2:0]  field_inc;
  logic        crc_ok;

  // hold off while the command queue is full or a write-many run drains the word store
  assign in_tready = !q_full && !run_pending_r;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign crc_b     = crc_feed(crc_r, b);
  assign field_inc = field_cnt_r + 3'd1;
  assign crc_ok    = (crc_low_r == crc_r[7:0]) && (b == crc_r[15:8]);

  // parser next state
  always_comb begin
    phase_nxt      = phase_r;
    field_cnt_nxt  = field_cnt_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    crc_low_nxt    = crc_low_r;
    held_func_nxt  = held_func_r;
    held_addr_nxt  = held_addr_r;
    held_count_nxt = held_count_r;
    kind_nxt       = kind_r;
    byte_pos_nxt   = byte_pos_r;
    hi_byte_nxt    = hi_byte_r;
    q_push         = 1'b0;
    q_cmd          = '{outcome: OUT_READ, function_code: held_func_r,
                       reg_address: held_addr_r, count_or_value: held_count_r,
                       run: 1'b0, n_words: '0};
    ram_we         = 1'b0;
    ram_waddr      = WADDR_W'(byte_pos_r >> 1);
    ram_wdata      = {hi_byte_r, b};

    if (accept) begin
      if (in_tuser == ITEM_IDLE) begin
        phase_nxt      = PH_HUNT;
        field_cnt_nxt  = '0;
        bytes_left_nxt = '0;
        crc_nxt        = CRC_SEED;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            field_cnt_nxt = '0;
            if (b == cfg.slave_address) begin
              crc_nxt   = crc_feed(CRC_SEED, b);
              phase_nxt = PH_FUNC;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_FUNC: begin
            crc_nxt        = crc_b;
            held_func_nxt  = b;
            held_addr_nxt  = '0;
            held_count_nxt = '0;
            field_cnt_nxt  = '0;
            phase_nxt      = PH_HDR;
            // priority: read, then write one, then write many
            if (b == cfg.read_code) begin
              kind_nxt = KIND_READ;
            end else if (b == cfg.write_one_code) begin
              kind_nxt = KIND_ONE;
            end else if (b == cfg.write_many_code) begin
              kind_nxt = KIND_MANY;
            end else begin
              phase_nxt = PH_SKIP;
              q_push    = 1'b1;
              q_cmd     = '{outcome: OUT_ILLEGAL, function_code: b, reg_address: '0,
                            count_or_value: '0, run: 1'b0, n_words: '0};
            end
          end
          PH_HDR: begin
            crc_nxt = crc_b;
            case (field_cnt_r[1:0])
              2'd0:    held_addr_nxt  = {b, held_addr_r[7:0]};
              2'd1:    held_addr_nxt  = {held_addr_r[15:8], b};
              2'd2:    held_count_nxt = {b, held_count_r[7:0]};
              default: held_count_nxt = {held_count_r[15:8], b};
            endcase
            field_cnt_nxt = field_inc;
            if (field_inc >= 3'd4) begin
              field_cnt_nxt = '0;
              if (kind_r == KIND_MANY && held_count_nxt != '0) begin
                bytes_left_nxt = {held_count_nxt, 1'b0};
                byte_pos_nxt   = '0;
                phase_nxt      = PH_DATA;
              end else begin
                bytes_left_nxt = '0;
                phase_nxt      = PH_CRCL;
              end
            end
          end
          PH_DATA: begin
            crc_nxt = crc_b;
            // words are stored only when the run fits the limit
            if (held_count_r <= 16'(WORD_LIMIT)) begin
              if (!byte_pos_r[0]) begin
                hi_byte_nxt = b;
              end else begin
                ram_we = 1'b1;
              end
              byte_pos_nxt = byte_pos_r + BPOS_W'(1);
            end
            if (bytes_left_r != '0) begin
              bytes_left_nxt = bytes_left_r - 17'd1;
            end
            if (bytes_left_nxt == '0) begin
              phase_nxt = PH_CRCL;
            end
          end
          PH_CRCL: begin
            crc_low_nxt = b;
            phase_nxt   = PH_CRCH;
          end
          PH_CRCH: begin
            phase_nxt      = PH_HUNT;
            crc_nxt        = CRC_SEED;
            field_cnt_nxt  = '0;
            bytes_left_nxt = '0;
            q_push         = 1'b1;
            if (!crc_ok) begin
              q_cmd.outcome = OUT_CRC_ERR;
            end else if (kind_r == KIND_READ) begin
              q_cmd.outcome = OUT_READ;
            end else if (kind_r == KIND_ONE) begin
              q_cmd.outcome = OUT_WRITE_ONE;
            end else if (held_count_r == '0) begin
              q_cmd.outcome = OUT_WORD;
            end else if (held_count_r > 16'(WORD_LIMIT)) begin
              q_cmd.outcome = OUT_TOO_MANY;
            end else begin
              q_cmd.outcome = OUT_WORD;
              q_cmd.run     = 1'b1;
              q_cmd.n_words = CNT_W'(held_count_r);
            end
          end
          PH_SKIP: begin
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  // run interlock: set on a run push, cleared when the back end finishes it
  always_comb begin
    run_pending_nxt = run_pending_r;
    if (q_push && q_cmd.run) begin
      run_pending_nxt = 1'b1;
    end else if (run_done) begin
      run_pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      field_cnt_r   <= '0;
      bytes_left_r  <= '0;
      crc_r         <= CRC_SEED;
      crc_low_r     <= '0;
      held_func_r   <= '0;
      held_addr_r   <= '0;
      held_count_r  <= '0;
      kind_r        <= KIND_READ;
      byte_pos_r    <= '0;
      run_pending_r <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      field_cnt_r   <= field_cnt_nxt;
      bytes_left_r  <= bytes_left_nxt;
      crc_r         <= crc_nxt;
      crc_low_r     <= crc_low_nxt;
      held_func_r   <= held_func_nxt;
      held_addr_r   <= held_addr_nxt;
      held_count_r  <= held_count_nxt;
      kind_r        <= kind_nxt;
      byte_pos_r    <= byte_pos_nxt;
      run_pending_r <= run_pending_nxt;
    end
  end

  // high data byte staging
  always_ff @(posedge clk) begin
    hi_byte_r <= hi_byte_nxt;
  end

endmodule

FILE: hdl/mbrx_back.sv
// ============================================================================
// mbrx_back
// Result sequencer: turns queued commands into result transactions, reading
// the word store one word at a time for a write-many run.
// ============================================================================
module mbrx_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mbrx_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          run_done,
  output logic                          ram_re,
  output logic [mbrx_pkg::WADDR_W-1:0]  ram_raddr,
  input  logic [15:0]                   ram_rdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,
  output logic [2:0]                    out_tuser,
  output logic                          out_tlast
);

  import mbrx_pkg::*;

  bstate_t     state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;
  outcome_t    outcome_r, outcome_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] cv_r, cv_nxt;
  logic [15:0] wv_r, wv_nxt;
  logic        last_r, last_nxt;

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    outcome_nxt = outcome_r;
    func_nxt    = func_r;
    addr_nxt    = addr_r;
    cv_nxt      = cv_r;
    wv_nxt      = wv_r;
    last_nxt    = last_r;
    q_pop       = 1'b0;
    run_done    = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          outcome_nxt = q_cmd.outcome;
          func_nxt    = q_cmd.function_code;
          addr_nxt    = q_cmd.reg_address;
          cv_nxt      = q_cmd.count_or_value;
          idx_nxt     = '0;
          if (q_cmd.run) begin
            ram_re    = 1'b1;
            state_nxt = B_READ;
          end else begin
            wv_nxt    = '0;
            last_nxt  = 1'b1;
            state_nxt = B_OUT;
          end
        end
      end
      B_READ: begin
        wv_nxt    = ram_rdata;
        last_nxt  = ((CNT_W'(idx_r) + CNT_W'(1)) == q_cmd.n_words);
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_tready) begin
          if (last_r) begin
            q_pop     = 1'b1;
            run_done  = q_cmd.run;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 5'd1;
            ram_re    = 1'b1;
            ram_raddr = WADDR_W'(idx_nxt);
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    outcome_r <= outcome_nxt;
    func_r    <= func_nxt;
    addr_r    <= addr_nxt;
    cv_r      <= cv_nxt;
    wv_r      <= wv_nxt;
    last_r    <= last_nxt;
  end

  assign out_tvalid = (state_r == B_OUT);
  assign out_tuser  = outcome_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {3'b000, wv_r, idx_r, cv_r, addr_r, func_r};

endmodule

FILE: hdl/mbrx_checker.sv
// ============================================================================
// mbrx_checker
// Port-level checks on the request receiver, bound to the top level.
// ============================================================================
module mbrx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [63:0]                     out_tdata,
  input logic [2:0]                      out_tuser,
  input logic                            out_tlast
);

  import mbrx_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // only defined outcome codes leave the block
  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= 3'(OUT_TOO_MANY)))
    else $error("undefined outcome code");

  // every result other than a word is a run of one
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != 3'(OUT_WORD)) |-> out_tlast)
    else $error("single result without last");

  // word fields are zero outside a write-many run
  a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != 3'(OUT_WORD)) |-> (out_tdata[63:40] == 24'd0))
    else $error("word fields set on a non-word result");

  // a word result that is not last is followed by a higher index
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == 3'(OUT_WORD)) && !out_tlast
    |=> ##1 out_tvalid && (out_tdata[44:40] == ($past(out_tdata[44:40], 2) + 5'd1)))
    else $error("write-many word index out of order");

endmodule

bind modbus_rtu_request_receiver mbrx_checker u_mbrx_checker (.*);

FILE: sim/modbus_rtu_request_receiver_tb.sv
// ============================================================================
// modbus_rtu_request_receiver_tb
// Self-checking testbench for the Modbus RTU request receiver.
// ============================================================================
// Builds request frames with a correct or damaged CRC-16 and feeds them
// byte by byte on the in_ stream, mixed with idle-gap marks, noise, foreign
// addresses, unknown codes and cut-off frames. A scoreboard object tracks the
// parser state, predicts every result transaction and compares it field by
// field with what comes out of the out_ stream. Both sides idle at random,
// and one long receiver hold-off backs the block up into its input. The
// function codes and slave address are reprogrammed between phases over the
// cfg_ port, equal codes and extreme values included.
// ============================================================================
module modbus_rtu_request_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrx_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_HOLD  = 400;
  localparam int SETTLE_CYCLES  = 30;
  localparam int DRAIN_CYCLES   = 40;

  // Frame damage kinds
  localparam int DMG_NONE  = 0;
  localparam int DMG_FLIP  = 1;
  localparam int DMG_TRUNC = 2;
  localparam int DMG_GAP   = 3;

  // One expected result transaction
  typedef struct {
    outcome_t    outcome;
    logic [7:0]  fcode;
    logic [15:0] raddr;
    logic [15:0] cval;
    logic [4:0]  widx;
    logic [15:0] wval;
    logic        last;
  } request_t;

  // CRC-16 update, one input bit at a time (reflected)
  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Frame parser scoreboard
  // --------------------------------------------------------------------------
  class frame_checker;
    logic [7:0]  own_addr, code_read, code_one, code_many;
    phase_t      ph;
    int          hdr_pos;
    int          bytes_left;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [7:0]  fcode;
    logic [15:0] raddr, rcount;
    kind_t       kind;
    logic [15:0] words [WORD_SLOTS];
    request_t    expected_requests[$];
    int          errors;

    function new();
      own_addr   = 8'd1;
      code_read  = 8'd4;
      code_one   = 8'd6;
      code_many  = 8'd16;
      ph         = PH_HUNT;
      hdr_pos    = 0;
      bytes_left = 0;
      crc        = CRC_SEED;
      crc_lo     = 8'h00;
      fcode      = 8'h00;
      raddr      = 16'h0000;
      rcount     = 16'h0000;
      kind       = KIND_READ;
      errors     = 0;
      foreach (words[i]) words[i] = 16'h0000;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_SLAVE_ADDR: own_addr   = v;
        REG_READ_CODE:  code_read  = v;
        REG_ONE_CODE:   code_one   = v;
        REG_MANY_CODE:  code_many  = v;
      endcase
    endfunction

    function void emit(outcome_t o, logic [15:0] cv, logic [4:0] wi, logic [15:0] wv,
                       logic lst);
      request_t r;
      r.outcome = o;
      r.fcode   = fcode;
      r.raddr   = raddr;
      r.cval    = cv;
      r.widx    = wi;
      r.wval    = wv;
      r.last    = lst;
      expected_requests.push_back(r);
    endfunction

    // Advance the parser by one accepted input transaction
    function void take_item(logic idle, logic [7:0] b);
      int total;
      int pos;
      if (idle) begin
        ph         = PH_HUNT;
        hdr_pos    = 0;
        bytes_left = 0;
        crc        = CRC_SEED;
        return;
      end
      case (ph)
        PH_HUNT: begin
          hdr_pos = 0;
          if (b == own_addr) begin
            crc = crc16_next(CRC_SEED, b);
            ph  = PH_FUNC;
          end else begin
            ph = PH_SKIP;
          end
        end
        PH_FUNC: begin
          crc     = crc16_next(crc, b);
          fcode   = b;
          raddr   = 16'h0000;
          rcount  = 16'h0000;
          hdr_pos = 0;
          // read beats write one beats write many on equal codes
          if (b == code_read) begin
            kind = KIND_READ;
          end else if (b == code_one) begin
            kind = KIND_ONE;
          end else if (b == code_many) begin
            kind = KIND_MANY;
          end else begin
            ph = PH_SKIP;
            emit(OUT_ILLEGAL, 16'h0000, 5'd0, 16'h0000, 1'b1);
            return;
          end
          ph = PH_HDR;
        end
        PH_HDR: begin
          crc = crc16_next(crc, b);
          case (hdr_pos)
            0:       raddr[15:8]  = b;
            1:       raddr[7:0]   = b;
            2:       rcount[15:8] = b;
            default: rcount[7:0]  = b;
          endcase
          hdr_pos++;
          if (hdr_pos == 4) begin
            hdr_pos = 0;
            if (kind == KIND_MANY && rcount != 0) begin
              bytes_left = 2 * rcount;
              ph         = PH_DATA;
            end else begin
              bytes_left = 0;
              ph         = PH_CRCL;
            end
          end
        end
        PH_DATA: begin
          crc   = crc16_next(crc, b);
          total = 2 * rcount;
          // over-long runs are checked but not stored
          if (rcount <= WORD_LIMIT && bytes_left != 0) begin
            pos = total - bytes_left;
            if (pos[0] == 1'b0) begin
              words[pos >> 1][15:8] = b;
            end else begin
              words[pos >> 1][7:0] = b;
            end
          end
          bytes_left--;
          if (bytes_left == 0) begin
            ph = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crc_lo = b;
          ph     = PH_CRCH;
        end
        PH_CRCH: begin
          ph         = PH_HUNT;
          hdr_pos    = 0;
          bytes_left = 0;
          if (crc_lo != crc[7:0] || b != crc[15:8]) begin
            emit(OUT_CRC_ERR, rcount, 5'd0, 16'h0000, 1'b1);
          end else if (kind == KIND_READ) begin
            emit(OUT_READ, rcount, 5'd0, 16'h0000, 1'b1);
          end else if (kind == KIND_ONE) begin
            emit(OUT_WRITE_ONE, rcount, 5'd0, 16'h0000, 1'b1);
          end else if (rcount == 0) begin
            emit(OUT_WORD, 16'h0000, 5'd0, 16'h0000, 1'b1);
          end else if (rcount > WORD_LIMIT) begin
            emit(OUT_TOO_MANY, rcount, 5'd0, 16'h0000, 1'b1);
          end else begin
            for (int k = 0; k < rcount; k++) begin
              emit(OUT_WORD, rcount, 5'(k), words[k], k == rcount - 1);
            end
          end
          crc = CRC_SEED;
        end
        PH_SKIP: begin
        end
        default: ph = PH_HUNT;
      endcase
    endfunction

    function void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Check one accepted result transaction against the oldest prediction
    function void check_result(logic [63:0] d, logic [2:0] u, logic l);
      request_t e;
      if (expected_requests.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual outcome %0d tdata %h",
                 $time, u, d);
        return;
      end
      e = expected_requests.pop_front();
      compare("outcome", 16'(e.outcome), 16'(u));
      compare("function_code", 16'(e.fcode), 16'(d[7:0]));
      compare("reg_address", e.raddr, d[23:8]);
      compare("count_or_value", e.cval, d[39:24]);
      compare("word_index", 16'(e.widx), 16'(d[44:40]));
      compare("word_value", e.wval, d[60:45]);
      compare("tdata pad", 16'h0000, 16'(d[63:61]));
      compare("last", 16'(e.last), 16'(l));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = 8'h00;
  logic                  in_tuser    = ITEM_BYTE;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [63:0]           out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  frame_checker sb;
  int  send_burst   = 0;
  int  recv_burst   = 0;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  bit  sender_fast  = 1'b0;
  bit  pressure_arm = 1'b0;
  bit  line_clean   = 1'b1;

  always #2 clk = ~clk;

  modbus_rtu_request_receiver uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Idle cycles before a transaction, with occasional bursts of none
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_item(logic idle, logic [7:0] b);
    int gap;
    gap = sender_fast ? 0 : draw_gap(send_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= idle ? ITEM_IDLE : ITEM_BYTE;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(idle, b);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_gap();
    send_item(1'b1, 8'($urandom));
  endtask

  // Address, code, four header bytes, 2*nwords data bytes, CRC low then high
  task automatic send_frame(logic [7:0] sa, logic [7:0] fc, logic [15:0] ra,
                            logic [15:0] cv, int nwords, int damage);
    logic [7:0]  q[$];
    logic [15:0] c;
    int          k;
    int          cut;
    q = '{sa, fc, ra[15:8], ra[7:0], cv[15:8], cv[7:0]};
    repeat (2 * nwords) q.push_back(8'($urandom));
    c = CRC_SEED;
    foreach (q[i]) c = crc16_next(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    if (damage == DMG_FLIP) begin
      k    = $urandom_range(2, q.size() - 1);
      q[k] = q[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    cut = (damage == DMG_TRUNC || damage == DMG_GAP) ? $urandom_range(1, q.size() - 1)
                                                     : q.size();
    foreach (q[i]) begin
      if (i == cut) begin
        send_gap();
        if (damage == DMG_TRUNC) break;
      end
      send_byte(q[i]);
    end
  endtask

  // Mostly well-formed frames for the current codes, some noise and damage
  task automatic random_frame();
    int          pick;
    int          r;
    int          nw;
    int          dmg;
    logic [7:0]  sa, fc;
    logic [15:0] ra, cv;
    if (!line_clean || $urandom_range(0, 3) == 0) send_gap();
    line_clean = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      send_gap();
      return;
    end
    sa = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.own_addr;
    r  = $urandom_range(0, 99);
    if (r < 30) fc = sb.code_read;
    else if (r < 50) fc = sb.code_one;
    else if (r < 85) fc = sb.code_many;
    else fc = 8'($urandom);
    ra = 16'($urandom);
    cv = 16'($urandom);
    nw = 0;
    if (fc != sb.code_read && fc != sb.code_one && fc == sb.code_many) begin
      r = $urandom_range(0, 99);
      if (r < 5) cv = 16'd0;
      else if (r < 75) cv = 16'($urandom_range(1, 6));
      else if (r < 88) cv = 16'($urandom_range(7, WORD_LIMIT - 1));
      else if (r < 94) cv = 16'(WORD_LIMIT);
      else cv = 16'($urandom_range(WORD_LIMIT + 1, WORD_LIMIT + 6));
      nw = cv;
    end
    r = $urandom_range(0, 99);
    if (r < 80) dmg = DMG_NONE;
    else if (r < 90) dmg = DMG_FLIP;
    else if (r < 95) dmg = DMG_TRUNC;
    else dmg = DMG_GAP;
    // anything that leaves the parser mid-frame or skipping needs a gap next
    if (sa != sb.own_addr || dmg != DMG_NONE ||
        (fc != sb.code_read && fc != sb.code_one && fc != sb.code_many)) begin
      line_clean = 1'b0;
    end
    send_frame(sa, fc, ra, cv, nw, dmg);
  endtask

  task automatic random_phase(int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) random_frame();
    send_gap();
  endtask

  // Stop offering and let every predicted result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration side
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {junk, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] sa, logic [7:0] rc, logic [7:0] oc, logic [7:0] mc);
    write_reg(REG_SLAVE_ADDR, sa);
    write_reg(REG_READ_CODE, rc);
    write_reg(REG_ONE_CODE, oc);
    write_reg(REG_MANY_CODE, mc);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pressure_arm) begin
        out_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        pressure_arm = 1'b0;
      end else begin
        gap = draw_gap(recv_burst);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[modbus_rtu_request_receiver] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed checks with the reset codes
    send_gap();
    send_frame(sb.own_addr, sb.code_read, 16'hFFFF, 16'hFFFF, 0, DMG_NONE);
    send_frame(sb.own_addr, sb.code_one, 16'h0000, 16'h0000, 0, DMG_FLIP);
    // foreign address, then unknown function code
    send_byte(8'h00);
    send_byte(sb.code_read);
    send_gap();
    send_byte(sb.own_addr);
    send_byte(8'hFF);
    send_gap();
    // write many with a count of zero
    send_frame(sb.own_addr, sb.code_many, 16'h1234, 16'h0000, 0, DMG_NONE);
    random_phase(30);

    // back-to-back word runs against a stalled receiver
    settle();
    pressure_arm = 1'b1;
    sender_fast  = 1'b1;
    repeat (6) send_frame(sb.own_addr, sb.code_many, 16'($urandom), 16'd4, 4, DMG_NONE);
    sender_fast  = 1'b0;

    // extreme register values
    settle();
    set_config(8'hFF, 8'h00, 8'hFF, 8'h80);
    random_phase(40);

    // all codes equal: read takes priority
    settle();
    set_config(8'h00, 8'h2A, 8'h2A, 8'h2A);
    random_phase(25);

    // write one and write many share a code
    settle();
    set_config(8'($urandom), 8'h55, 8'h77, 8'h77);
    random_phase(25);

    // random register values
    settle();
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(25);

    in_tvalid <= 1'b0;
    while (sb.expected_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_requests.size() == 0) begin
      $display("[modbus_rtu_request_receiver] OK");
    end else begin
      $display("[modbus_rtu_request_receiver] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mbrx_pkg.sv
hdl/mbrx_ram.sv
hdl/mbrx_queue.sv
hdl/mbrx_front.sv
hdl/mbrx_back.sv
hdl/modbus_rtu_request_receiver.sv
hdl/mbrx_checker.sv
sim/modbus_rtu_request_receiver_tb.sv
